// ===== sv/src_pkg.sv =====
package src_pkg;

  // upper bound on the slot size setting
  localparam int unsigned MAX_SLOT_BYTES = 512;

  localparam int unsigned POS_W    = 10;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned LEN_W    = 16;

  // slot limit held one bit wider than the setting so the full range compares
  localparam logic [CFG_W:0] SLOT_LIMIT = (CFG_W + 1)'(MAX_SLOT_BYTES);

  localparam logic [7:0]       MAGIC_BYTE       = 8'hA5;
  localparam logic [15:0]      CRC_START        = 16'hFFFF;
  localparam logic [15:0]      CRC_TOP          = 16'h8000;
  localparam logic [15:0]      CRC_POLY         = 16'h1021;
  localparam logic [LEN_W-1:0] MIN_RECORD_BYTES = 16'd20;
  localparam logic [CFG_W-1:0] MAX_RECORD_RESET = 10'd512;
  localparam logic [CFG_W-1:0] V2_RECORD_RESET  = 10'd256;
  localparam logic [7:0]       VERSION_1        = 8'd1;
  localparam logic [7:0]       VERSION_2        = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_RECORD_BYTES = 1'b0,
    CFG_V2_RECORD_BYTES  = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MAGIC     = 3'd1,
    ST_VERSION   = 3'd2,
    ST_TAG       = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_TOO_SHORT = 3'd5,
    ST_V2_SIZE   = 3'd6,
    ST_CRC       = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  version;
    logic [15:0] record_length;
    logic [31:0] sequence_res;
    logic [15:0] computed_crc;
  } result_item_t;

  // fixed tag at header offsets 10 to 13
  function automatic logic [7:0] tag_byte(input logic [1:0] idx);
    logic [7:0] t;
    case (idx)
      2'd0:    t = 8'h52;
      2'd1:    t = 8'h34;
      2'd2:    t = 8'h38;
      default: t = 8'h43;
    endcase
    return t;
  endfunction

  // crc-16 update by one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/src_byte_if.sv =====
interface src_byte_if;
  logic                valid;
  logic                ready;
  src_pkg::byte_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/src_result_if.sv =====
interface src_result_if;
  logic                  valid;
  logic                  ready;
  src_pkg::result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/stored_record_checker.sv =====
// stored record checker: one record byte per item, header checks and crc-16
// throughput: one item per cycle; ready drops only while a result waits unread
// the result is registered and shows in the cycle after the byte that ends the check
// the byte-wide crc update and header checks sit in one level of logic before the state regs
// reset (rst, synchronous): idle, no result pending, slot size 512, v2 size 256
module stored_record_checker (
  input  logic                            clk,
  input  logic                            rst,
  src_byte_if.sink                        byte_in,
  src_result_if.source                    result_out,
  input  logic                            cfg_we,
  input  logic [src_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [src_pkg::CFG_W-1:0]       cfg_data
);

  // configuration registers
  logic [src_pkg::CFG_W-1:0] max_record_bytes;
  logic [src_pkg::CFG_W-1:0] v2_record_bytes;

  // record state
  logic [src_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]               running_crc, running_crc_next;
  logic [7:0]                held_version, held_version_next;
  logic [15:0]               held_length, held_length_next;
  logic [31:0]               held_sequence, held_sequence_next;
  logic [15:0]               held_stored_crc, held_stored_crc_next;
  src_pkg::status_t          header_fault, header_fault_next;
  logic                      record_active, record_active_next;

  // result register
  logic                  out_valid;
  src_pkg::result_item_t out_item, out_item_next;

  logic       accept;
  logic       active_cur;
  logic       emit;
  logic [7:0] b;
  logic [src_pkg::POS_W-1:0] pos;
  logic [src_pkg::CFG_W:0]   slot;
  logic [src_pkg::POS_W:0]   pos_plus1;

  assign byte_in.ready   = !out_valid || result_out.ready;
  assign accept          = byte_in.valid && byte_in.ready;
  assign result_out.valid = out_valid;
  assign result_out.data  = out_item;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_record_bytes <= src_pkg::MAX_RECORD_RESET;
      v2_record_bytes  <= src_pkg::V2_RECORD_RESET;
    end else if (cfg_we) begin
      case (src_pkg::cfg_index_t'(cfg_index))
        src_pkg::CFG_MAX_RECORD_BYTES: max_record_bytes <= cfg_data;
        src_pkg::CFG_V2_RECORD_BYTES:  v2_record_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-byte header check and crc step
  always_comb begin
    b = byte_in.data.data_byte;
    if (byte_in.data.first) begin
      active_cur           = 1'b1;
      pos                  = '0;
      running_crc_next     = src_pkg::CRC_START;
      held_version_next    = '0;
      held_length_next     = '0;
      held_sequence_next   = '0;
      held_stored_crc_next = '0;
      header_fault_next    = src_pkg::ST_OK;
    end else begin
      active_cur           = record_active;
      pos                  = byte_position;
      running_crc_next     = running_crc;
      held_version_next    = held_version;
      held_length_next     = held_length;
      held_sequence_next   = held_sequence;
      held_stored_crc_next = held_stored_crc;
      header_fault_next    = header_fault;
    end

    // capture header fields and look for faults
    if (pos == 10'd0) begin
      if (b != src_pkg::MAGIC_BYTE && header_fault_next == src_pkg::ST_OK) begin
        header_fault_next = src_pkg::ST_MAGIC;
      end
    end else if (pos == 10'd1) begin
      held_version_next = b;
      if (b != src_pkg::VERSION_1 && b != src_pkg::VERSION_2 &&
          header_fault_next == src_pkg::ST_OK) begin
        header_fault_next = src_pkg::ST_VERSION;
      end
    end else if (pos <= 10'd3) begin
      held_length_next[8*pos[0] +: 8] = held_length_next[8*pos[0] +: 8] | b;
    end else if (pos <= 10'd7) begin
      held_sequence_next[8*pos[1:0] +: 8] = held_sequence_next[8*pos[1:0] +: 8] | b;
    end else if (pos <= 10'd9) begin
      held_stored_crc_next[8*pos[0] +: 8] = held_stored_crc_next[8*pos[0] +: 8] | b;
    end else if (pos <= 10'd13) begin
      if (b != src_pkg::tag_byte(2'(pos[1:0] - 2'd2)) &&
          header_fault_next == src_pkg::ST_OK) begin
        header_fault_next = src_pkg::ST_TAG;
      end
    end

    // crc covers everything from byte 1 but the stored crc
    if (pos != 10'd0 && pos != 10'd8 && pos != 10'd9) begin
      running_crc_next = src_pkg::crc_byte(running_crc_next, b);
    end

    // length checks once the header is complete
    slot = ({1'b0, max_record_bytes} > src_pkg::SLOT_LIMIT) ?
           src_pkg::SLOT_LIMIT : {1'b0, max_record_bytes};
    if (pos == 10'd15 && header_fault_next == src_pkg::ST_OK) begin
      if (held_length_next > 16'(slot)) begin
        header_fault_next = src_pkg::ST_TOO_LONG;
      end else if (held_length_next < src_pkg::MIN_RECORD_BYTES) begin
        header_fault_next = src_pkg::ST_TOO_SHORT;
      end else if (held_version_next == src_pkg::VERSION_2 &&
                   held_length_next != 16'(v2_record_bytes)) begin
        header_fault_next = src_pkg::ST_V2_SIZE;
      end
    end

    // result selection
    pos_plus1 = {1'b0, pos} + 11'd1;
    emit      = 1'b0;
    out_item_next.version       = held_version_next;
    out_item_next.record_length = held_length_next;
    out_item_next.sequence_res  = held_sequence_next;
    out_item_next.status        = src_pkg::ST_OK;
    out_item_next.computed_crc  = running_crc_next;
    if (pos == 10'd15 && header_fault_next != src_pkg::ST_OK) begin
      emit = 1'b1;
      out_item_next.status       = header_fault_next;
      out_item_next.computed_crc = '0;
    end else if (pos >= 10'd15 && 16'(pos_plus1) >= held_length_next) begin
      emit = 1'b1;
      out_item_next.status = (running_crc_next == held_stored_crc_next) ?
                             src_pkg::ST_OK : src_pkg::ST_CRC;
    end

    record_active_next = active_cur && !emit;
    byte_position_next = emit ? pos : 10'(pos_plus1);
  end

  // record state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      running_crc     <= src_pkg::CRC_START;
      held_version    <= '0;
      held_length     <= '0;
      held_sequence   <= '0;
      held_stored_crc <= '0;
      header_fault    <= src_pkg::ST_OK;
      record_active   <= 1'b0;
    end else if (accept && active_cur) begin
      byte_position   <= byte_position_next;
      running_crc     <= running_crc_next;
      held_version    <= held_version_next;
      held_length     <= held_length_next;
      held_sequence   <= held_sequence_next;
      held_stored_crc <= held_stored_crc_next;
      header_fault    <= header_fault_next;
      record_active   <= record_active_next;
    end
  end

  // result register and its valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && active_cur && emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active_cur && emit) begin
      out_item <= out_item_next;
    end
  end

endmodule

// ===== verif/stored_record_checker_test.sv =====
module stored_record_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import src_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES = 6;
  localparam int ITEMS_TOTAL = 1350;

  // expected record results and the checker state behind them
  class record_scoreboard;
    logic [CFG_W-1:0] slot_setting;
    logic [CFG_W-1:0] v2_size;
    logic [9:0]       pos;
    logic [15:0]      crc;
    logic [7:0]       ver;
    logic [15:0]      len;
    logic [31:0]      seq;
    logic [15:0]      stored;
    status_t          fault;
    bit               active;
    result_item_t     awaited[$];
    int               errors;
    int               results_seen;
    int               bytes_taken;
    int               status_count[8];

    static function logic [15:0] crc_step(logic [15:0] c_in, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = c_in;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    static function logic [7:0] tag_at(int k);
      logic [7:0] t;
      case (k)
        0: t = 8'h52;
        1: t = 8'h34;
        2: t = 8'h38;
        default: t = 8'h43;
      endcase
      return t;
    endfunction

    function void power_up();
      slot_setting = MAX_RECORD_RESET;
      v2_size = V2_RECORD_RESET;
      pos = '0;
      crc = CRC_START;
      ver = '0;
      len = '0;
      seq = '0;
      stored = '0;
      fault = ST_OK;
      active = 1'b0;
      errors = 0;
      results_seen = 0;
      bytes_taken = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_MAX_RECORD_BYTES: slot_setting = v;
        CFG_V2_RECORD_BYTES: v2_size = v;
        default: ;
      endcase
    endfunction

    function void queue_result(status_t s, logic [15:0] c);
      awaited.push_back('{status: s, version: ver, record_length: len,
                          sequence_res: seq, computed_crc: c});
    endfunction

    // one record byte through the header checks and the crc
    function void absorb_byte(byte_item_t it);
      logic [7:0] b;
      int         slot;
      b = it.data_byte;
      if (it.first) begin
        pos = '0;
        crc = CRC_START;
        ver = '0;
        len = '0;
        seq = '0;
        stored = '0;
        fault = ST_OK;
        active = 1'b1;
      end
      if (!active) return;
      bytes_taken++;
      case (pos)
        10'd0: if (b != MAGIC_BYTE && fault == ST_OK) fault = ST_MAGIC;
        10'd1: begin
          ver = b;
          if (b != VERSION_1 && b != VERSION_2 && fault == ST_OK) fault = ST_VERSION;
        end
        10'd2: len[7:0] = b;
        10'd3: len[15:8] = b;
        10'd4: seq[7:0] = b;
        10'd5: seq[15:8] = b;
        10'd6: seq[23:16] = b;
        10'd7: seq[31:24] = b;
        10'd8: stored[7:0] = b;
        10'd9: stored[15:8] = b;
        10'd10, 10'd11, 10'd12, 10'd13: begin
          if (b != tag_at(int'(pos) - 10) && fault == ST_OK) fault = ST_TAG;
        end
        default: ;
      endcase
      // the stored crc bytes and the magic stay out of the crc
      if (pos != 10'd0 && pos != 10'd8 && pos != 10'd9) crc = crc_step(crc, b);
      if (pos == 10'd15) begin
        slot = (slot_setting > MAX_SLOT_BYTES) ? MAX_SLOT_BYTES : int'(slot_setting);
        if (fault == ST_OK) begin
          if (len > slot) fault = ST_TOO_LONG;
          else if (len < MIN_RECORD_BYTES) fault = ST_TOO_SHORT;
          else if (ver == VERSION_2 && len != v2_size) fault = ST_V2_SIZE;
        end
        if (fault != ST_OK) begin
          active = 1'b0;
          queue_result(fault, 16'h0000);
          return;
        end
      end
      if (pos >= 10'd15 && int'(pos) + 1 >= int'(len)) begin
        active = 1'b0;
        queue_result((crc == stored) ? ST_OK : ST_CRC, crc);
        return;
      end
      pos = pos + 10'd1;
    endfunction

    task report(string what);
      if (errors < 40) $display("mismatch: %s", what);
      errors++;
    endtask

    task compare_result(result_item_t got);
      result_item_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with status %0d while none expected", got.status));
        return;
      end
      want = awaited.pop_front();
      results_seen++;
      status_count[int'(want.status)]++;
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.version !== want.version)
        report($sformatf("version %0h, want %0h", got.version, want.version));
      if (got.record_length !== want.record_length)
        report($sformatf("length %0h, want %0h", got.record_length, want.record_length));
      if (got.sequence_res !== want.sequence_res)
        report($sformatf("sequence %0h, want %0h", got.sequence_res, want.sequence_res));
      if (got.computed_crc !== want.computed_crc)
        report($sformatf("crc %0h, want %0h", got.computed_crc, want.computed_crc));
    endtask

    task leftover_check();
      if (awaited.size() != 0)
        report($sformatf("%0d expected results never came", awaited.size()));
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  cfg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  src_byte_if   byte_ch ();
  src_result_if result_ch ();

  stored_record_checker u_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_ch),
    .result_out (result_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  record_scoreboard sb;
  logic [7:0]       rec[$];
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               bytes_sent = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random stalls, check each accepted item
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        sb.compare_result(result_ch.data);
      result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
          (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) stall = 0;
      else stall++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(logic [7:0] d, logic f);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data <= '{data_byte: d, first: f};
    @(posedge clk);
    while (byte_ch.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    sb.absorb_byte('{data_byte: d, first: f});
  endtask

  task automatic send_record(int count);
    for (int i = 0; i < count; i++) send_item(rec[i], i == 0);
  endtask

  // stop sending until every expected result is back, then let the block settle
  task automatic drain();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_W-1:0] max_bytes, logic [CFG_W-1:0] v2_bytes);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_RECORD_BYTES;
    cfg_data <= max_bytes;
    @(posedge clk);
    cfg_index <= CFG_V2_RECORD_BYTES;
    cfg_data <= v2_bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(CFG_MAX_RECORD_BYTES, max_bytes);
    sb.set_register(CFG_V2_RECORD_BYTES, v2_bytes);
  endtask

  // header, random body and a stored crc over bytes 1 to length-1
  function automatic void compose_record(logic [7:0] magic, logic [7:0] ver,
                                         logic [15:0] len_field, logic [31:0] seq,
                                         int n_bytes, bit crc_good);
    logic [15:0] c;
    int          stop;
    rec.delete();
    rec.push_back(magic);
    rec.push_back(ver);
    rec.push_back(len_field[7:0]);
    rec.push_back(len_field[15:8]);
    for (int k = 0; k < 4; k++) rec.push_back(seq[8*k +: 8]);
    rec.push_back(8'h00);
    rec.push_back(8'h00);
    for (int k = 0; k < 4; k++) rec.push_back(record_scoreboard::tag_at(k));
    while (rec.size() < n_bytes) rec.push_back(8'($urandom_range(0, 255)));
    c = CRC_START;
    stop = (int'(len_field) < n_bytes) ? int'(len_field) : n_bytes;
    for (int i = 1; i < stop; i++)
      if (i != 8 && i != 9) c = record_scoreboard::crc_step(c, rec[i]);
    if (!crc_good) c ^= 16'($urandom_range(1, 65535));
    rec[8] = c[7:0];
    rec[9] = c[15:8];
  endfunction

  task automatic directed_cases();
    // unmarked bytes while idle
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(MAGIC_BYTE, 1'b0);
    // good record at the shortest length
    compose_record(MAGIC_BYTE, VERSION_1, 16'd20, 32'hFFFF_FFFF, 20, 1'b1);
    send_record(rec.size());
    // version 2 size off by one
    compose_record(MAGIC_BYTE, VERSION_2, 16'd255, 32'h8000_0001, 16, 1'b1);
    send_record(rec.size());
    // bad magic outranks bad version
    compose_record(8'h5A, 8'd3, 16'd20, 32'h0, 16, 1'b1);
    send_record(rec.size());
    // bad versions
    compose_record(MAGIC_BYTE, 8'd0, 16'd20, 32'h0, 16, 1'b1);
    send_record(rec.size());
    compose_record(MAGIC_BYTE, 8'd3, 16'd20, 32'h0, 16, 1'b1);
    send_record(rec.size());
    compose_record(MAGIC_BYTE, 8'd255, 16'd20, 32'h0, 20, 1'b1);
    send_record(rec.size());
    // each tag byte broken
    for (int k = 0; k < 4; k++) begin
      compose_record(MAGIC_BYTE, VERSION_1, 16'd20, 32'h0, 20, 1'b1);
      rec[10+k] ^= 8'h01;
      send_record(rec.size());
    end
    // bad version outranks bad tag
    compose_record(MAGIC_BYTE, 8'd7, 16'd20, 32'h0, 16, 1'b1);
    rec[12] = 8'hFF;
    send_record(rec.size());
    // lengths over the slot, and tag outranking length
    compose_record(MAGIC_BYTE, VERSION_1, 16'd513, 32'h0, 16, 1'b1);
    send_record(rec.size());
    compose_record(MAGIC_BYTE, VERSION_1, 16'hFFFF, 32'h0, 16, 1'b1);
    send_record(rec.size());
    compose_record(MAGIC_BYTE, VERSION_1, 16'd513, 32'h0, 16, 1'b1);
    rec[13] = 8'h00;
    send_record(rec.size());
    // lengths under the minimum
    compose_record(MAGIC_BYTE, VERSION_1, 16'd19, 32'h0, 16, 1'b1);
    send_record(rec.size());
    compose_record(MAGIC_BYTE, VERSION_1, 16'd0, 32'h0, 16, 1'b1);
    send_record(rec.size());
    compose_record(MAGIC_BYTE, VERSION_2, 16'd16, 32'h0, 16, 1'b1);
    send_record(rec.size());
    // crc errors: stored value and last payload byte
    compose_record(MAGIC_BYTE, VERSION_1, 16'd20, 32'hA5A5_5A5A, 20, 1'b0);
    send_record(rec.size());
    compose_record(MAGIC_BYTE, VERSION_1, 16'd24, 32'h0, 24, 1'b1);
    rec[23] ^= 8'h80;
    send_record(rec.size());
    // marked byte mid-record: early, at the header end, at the last byte
    compose_record(MAGIC_BYTE, VERSION_1, 16'd30, 32'h0, 30, 1'b1);
    send_record(10);
    send_record(16);
    send_record(29);
    compose_record(MAGIC_BYTE, VERSION_1, 16'd20, 32'h0, 20, 1'b1);
    send_record(rec.size());
    // trailing bytes after a result are ignored
    for (int k = 0; k < 5; k++) send_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic random_burst();
    int          kind;
    int          len;
    int          slot;
    int          n;
    int          cut;
    logic [7:0]  ver;
    logic [15:0] lenv;
    slot = (sb.slot_setting > MAX_SLOT_BYTES) ? MAX_SLOT_BYTES : int'(sb.slot_setting);
    kind = $urandom_range(0, 99);
    if (kind < 93) begin
      ver = 8'($urandom_range(1, 2));
      // keep long version 2 records rare
      if (ver == VERSION_2 && sb.v2_size > 80 && $urandom_range(0, 7) != 0) ver = VERSION_1;
      if (ver == VERSION_2) len = int'(sb.v2_size);
      else if (slot < 20) len = 20;
      else if ($urandom_range(0, 19) == 0) len = $urandom_range(20, slot);
      else len = $urandom_range(20, (slot < 60) ? slot : 60);
      // an oversized record fails at the header end, so its body is not sent
      n = (len < 16 || len > slot) ? 16 : len;
      compose_record(MAGIC_BYTE, ver, 16'(len), $urandom, n, $urandom_range(0, 99) < 88);
      cut = n;
      if (kind >= 70 && kind < 85) begin
        // one broken header field
        case ($urandom_range(0, 5))
          0: rec[0] ^= 8'($urandom_range(1, 255));
          1: rec[1] = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(3, 255));
          2: rec[10+$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
          3: begin
            lenv = 16'($urandom_range(slot + 1, 65535));
            rec[2] = lenv[7:0];
            rec[3] = lenv[15:8];
          end
          4: begin
            lenv = 16'($urandom_range(0, 19));
            rec[2] = lenv[7:0];
            rec[3] = lenv[15:8];
          end
          default: begin
            lenv = 16'($urandom_range(0, 65535));
            rec[1] = VERSION_2;
            rec[2] = lenv[7:0];
            rec[3] = lenv[15:8];
          end
        endcase
        cut = 16 + $urandom_range(0, 4);
        if (cut > rec.size()) cut = rec.size();
      end else if (kind >= 85) begin
        // cut short, the next marked byte abandons it
        cut = $urandom_range(1, n - 1);
      end
      send_record(cut);
    end else begin
      // noise, now and then marked
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] max_cfg[PHASES];
    logic [CFG_W-1:0] v2_cfg[PHASES];
    int               stop_at;
    max_cfg = '{10'd512, 10'd20, 10'd1023, 10'd0, 10'd300, 10'($urandom_range(0, 1023))};
    v2_cfg = '{10'd256, 10'd20, 10'd512, 10'd1023, 10'd40, 10'($urandom_range(0, 1023))};
    sb = new;
    sb.power_up();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MAX_RECORD_BYTES;
    cfg_data <= '0;
    byte_ch.valid <= 1'b0;
    byte_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      // idle mix: sender light then heavy, then none
      case (p / 2)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (p == 0) begin
        directed_cases();
      end else begin
        drain();
        write_config(max_cfg[p], v2_cfg[p]);
      end
      // share what is left of the item budget over the remaining phases
      stop_at = bytes_sent + (ITEMS_TOTAL - bytes_sent) / (PHASES - p);
      while (bytes_sent < stop_at) begin
        random_burst();
        if ($urandom_range(0, 49) == 0) drain();
      end
    end

    drain();
    sb.leftover_check();
    $display("sent %0d bytes, %0d taken by records, %0d results checked over %0d phases",
             bytes_sent, sb.bytes_taken, sb.results_seen, PHASES);
    $display("results ok %0d magic %0d version %0d tag %0d long %0d short %0d v2 %0d crc %0d",
             sb.status_count[0], sb.status_count[1], sb.status_count[2], sb.status_count[3],
             sb.status_count[4], sb.status_count[5], sb.status_count[6], sb.status_count[7]);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/src_pkg.sv
sv/src_byte_if.sv
sv/src_result_if.sv
sv/stored_record_checker.sv
verif/stored_record_checker_test.sv
